// ===== rtl/keyframe_path_interpolator_unit_defines.svh =====
// assertion macros shared by the keyframe path interpolator modules
`ifndef KEYFRAME_PATH_INTERPOLATOR_UNIT_DEFINES_SVH
`define KEYFRAME_PATH_INTERPOLATOR_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define KPI_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define KPI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/kpi_pkg.sv =====
// shared constants and types of the keyframe path interpolator
`timescale 1ns / 1ps
`default_nettype none

package kpi_pkg;

    localparam int MAX_KEYS   = 256;
    localparam int FRAC_BITS  = 16;
    localparam int DATA_W     = 32;
    localparam int POS_W      = 32;
    localparam int LEN_W      = 9;
    localparam int KEY_IDX_W  = 8;
    localparam int NUM_FIELDS = 5;

    localparam int INT_W   = POS_W - FRAC_BITS;
    localparam int ADDR_W  = $clog2(MAX_KEYS);
    localparam int CNT_W   = $clog2(INT_W);
    localparam int FLD_W   = $clog2(NUM_FIELDS);
    localparam int WORD_W  = NUM_FIELDS * DATA_W;
    localparam int PROD_W  = DATA_W + FRAC_BITS + 2;

    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_RD_A,
        ST_RD_B,
        ST_MUL,
        ST_FLUSH,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic key_write;
        logic load;
        logic div_step;
        logic rd_a;
        logic rd_b;
        logic mul_step;
    } cmd_t;

    typedef struct packed {
        logic len_zero;
        logic div_last;
        logic fld_last;
    } status_t;

endpackage

`default_nettype wire

// ===== rtl/keyframe_path_interpolator_unit.sv =====
// top level of the keyframe path interpolator
`timescale 1ns / 1ps
`default_nettype none

// Looped camera path of up to 256 keyframes (x, y, z, zoom, roll, signed Q16.16).
// A request is taken when start is high and busy is low. With command low it
// writes the keyframe fields into slot key_index in that same cycle and gives
// no result; busy stays low, so writes may follow every cycle.
// With command high it samples the path at position (unsigned Q16.16). The
// integer part is reduced modulo the path length by a restoring divider, one
// bit a cycle, then the two keyframes are read from the store one after the
// other and the five fields go through one shared multiplier, one a cycle.
// The result shows on the out ports with done high for exactly one cycle,
// after the flush state; busy stays high until then, and the next request is
// taken the cycle after. With a path length of zero the result comes the
// cycle after the request, all fields zero and path_ok low.
// The user must write path_length through path_length_we only while busy is low;
// the block does not enforce it. Reset clears the path length to zero and the
// controller to idle; keyframe slots hold nothing defined until written. The
// receiver cannot stall: done marks a result that is taken in that cycle.

module keyframe_path_interpolator_unit (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 start,
    output logic                                      busy,
    input  wire logic                                 command,
    input  wire logic [kpi_pkg::KEY_IDX_W-1:0]        key_index,
    input  wire logic signed [kpi_pkg::DATA_W-1:0]    key_x,
    input  wire logic signed [kpi_pkg::DATA_W-1:0]    key_y,
    input  wire logic signed [kpi_pkg::DATA_W-1:0]    key_z,
    input  wire logic signed [kpi_pkg::DATA_W-1:0]    key_zoom,
    input  wire logic signed [kpi_pkg::DATA_W-1:0]    key_roll,
    input  wire logic [kpi_pkg::POS_W-1:0]            position,
    input  wire logic                                 path_length_we,
    input  wire logic [kpi_pkg::LEN_W-1:0]            path_length,
    output logic                                      done,
    output logic signed [kpi_pkg::DATA_W-1:0]         out_x,
    output logic signed [kpi_pkg::DATA_W-1:0]         out_y,
    output logic signed [kpi_pkg::DATA_W-1:0]         out_z,
    output logic signed [kpi_pkg::DATA_W-1:0]         out_zoom,
    output logic signed [kpi_pkg::DATA_W-1:0]         out_roll,
    output logic                                      path_ok
);

    kpi_pkg::cmd_t    cmd;
    kpi_pkg::status_t status;

    kpi_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .command (command),
        .status  (status),
        .cmd     (cmd),
        .busy    (busy),
        .done    (done)
    );

    kpi_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .key_index      (key_index),
        .key_x          (key_x),
        .key_y          (key_y),
        .key_z          (key_z),
        .key_zoom       (key_zoom),
        .key_roll       (key_roll),
        .position       (position),
        .path_length_we (path_length_we),
        .path_length    (path_length),
        .out_x          (out_x),
        .out_y          (out_y),
        .out_z          (out_z),
        .out_zoom       (out_zoom),
        .out_roll       (out_roll),
        .path_ok        (path_ok)
    );

endmodule

`default_nettype wire

// ===== rtl/kpi_ctrl.sv =====
// sequencing state machine of the keyframe path interpolator
`timescale 1ns / 1ps
`default_nettype none

`include "keyframe_path_interpolator_unit_defines.svh"

module kpi_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    input  wire logic            command,
    input  kpi_pkg::status_t     status,
    output kpi_pkg::cmd_t        cmd,
    output logic                 busy,
    output logic                 done
);

    kpi_pkg::state_t state_reg;
    kpi_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= kpi_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            kpi_pkg::ST_IDLE:
            begin
                if (start && (command == kpi_pkg::CMD_SAMPLE))
                begin
                    state_next = status.len_zero ? kpi_pkg::ST_DONE : kpi_pkg::ST_DIV;
                end
            end
            kpi_pkg::ST_DIV:
            begin
                if (status.div_last)
                begin
                    state_next = kpi_pkg::ST_RD_A;
                end
            end
            kpi_pkg::ST_RD_A:  state_next = kpi_pkg::ST_RD_B;
            kpi_pkg::ST_RD_B:  state_next = kpi_pkg::ST_MUL;
            kpi_pkg::ST_MUL:
            begin
                if (status.fld_last)
                begin
                    state_next = kpi_pkg::ST_FLUSH;
                end
            end
            kpi_pkg::ST_FLUSH: state_next = kpi_pkg::ST_DONE;
            kpi_pkg::ST_DONE:  state_next = kpi_pkg::ST_IDLE;
            default:           state_next = kpi_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        done = 1'b0;
        case (state_reg)
            kpi_pkg::ST_IDLE:
            begin
                busy          = 1'b0;
                cmd.key_write = start && (command == kpi_pkg::CMD_WRITE);
                cmd.load      = start && (command == kpi_pkg::CMD_SAMPLE);
            end
            kpi_pkg::ST_DIV:   cmd.div_step = 1'b1;
            kpi_pkg::ST_RD_A:  cmd.rd_a     = 1'b1;
            kpi_pkg::ST_RD_B:  cmd.rd_b     = 1'b1;
            kpi_pkg::ST_MUL:   cmd.mul_step = 1'b1;
            kpi_pkg::ST_FLUSH: busy         = 1'b1;
            kpi_pkg::ST_DONE:  done         = 1'b1;
            default:           busy         = 1'b1;
        endcase
    end

    `KPI_ASSERT_NEXT(a_done_single, done, !done, "result strobe held for more than one cycle")
    `KPI_ASSERT_NEXT(a_sample_busy, start && !busy && (command == kpi_pkg::CMD_SAMPLE), busy, "sample request not taken up")
    `KPI_ASSERT_NEXT(a_done_then_idle, done, !busy, "block not free after a result")

endmodule

`default_nettype wire

// ===== rtl/kpi_datapath.sv =====
// keyframe store, modulo divider and field interpolator
`timescale 1ns / 1ps
`default_nettype none

`include "keyframe_path_interpolator_unit_defines.svh"

module kpi_datapath (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  kpi_pkg::cmd_t                             cmd,
    output kpi_pkg::status_t                          status,
    input  wire logic [kpi_pkg::KEY_IDX_W-1:0]        key_index,
    input  wire logic signed [kpi_pkg::DATA_W-1:0]    key_x,
    input  wire logic signed [kpi_pkg::DATA_W-1:0]    key_y,
    input  wire logic signed [kpi_pkg::DATA_W-1:0]    key_z,
    input  wire logic signed [kpi_pkg::DATA_W-1:0]    key_zoom,
    input  wire logic signed [kpi_pkg::DATA_W-1:0]    key_roll,
    input  wire logic [kpi_pkg::POS_W-1:0]            position,
    input  wire logic                                 path_length_we,
    input  wire logic [kpi_pkg::LEN_W-1:0]            path_length,
    output logic signed [kpi_pkg::DATA_W-1:0]         out_x,
    output logic signed [kpi_pkg::DATA_W-1:0]         out_y,
    output logic signed [kpi_pkg::DATA_W-1:0]         out_z,
    output logic signed [kpi_pkg::DATA_W-1:0]         out_zoom,
    output logic signed [kpi_pkg::DATA_W-1:0]         out_roll,
    output logic                                      path_ok
);

    logic [kpi_pkg::LEN_W-1:0]      cfg_len_reg;
    logic [kpi_pkg::LEN_W-1:0]      len_clamped;

    logic [kpi_pkg::WORD_W-1:0]     mem [kpi_pkg::MAX_KEYS];
    logic [kpi_pkg::WORD_W-1:0]     rd_data_reg;
    logic [kpi_pkg::ADDR_W-1:0]     rd_addr;
    logic                           mem_we;

    logic [kpi_pkg::LEN_W-1:0]      len_reg;
    logic [kpi_pkg::INT_W-1:0]      ipart_reg;
    logic [kpi_pkg::LEN_W-1:0]      rem_reg;
    logic [kpi_pkg::LEN_W-1:0]      rem_next;
    logic [kpi_pkg::LEN_W:0]        rem_shift;
    logic [kpi_pkg::CNT_W-1:0]      cnt_reg;
    logic [kpi_pkg::LEN_W:0]        k_inc;
    logic [kpi_pkg::FRAC_BITS-1:0]  frac_reg;
    logic                           path_ok_reg;

    logic [kpi_pkg::WORD_W-1:0]     a_reg;
    logic [kpi_pkg::FLD_W-1:0]      fld_reg;
    logic [kpi_pkg::DATA_W-1:0]     a_fld;
    logic [kpi_pkg::DATA_W-1:0]     b_fld;
    logic signed [kpi_pkg::DATA_W:0]   diff;
    logic signed [kpi_pkg::PROD_W-1:0] prod_next;
    logic signed [kpi_pkg::PROD_W-1:0] prod_reg;
    logic [kpi_pkg::DATA_W-1:0]     a_hold_reg;
    logic [kpi_pkg::FLD_W-1:0]      prod_fld_reg;
    logic                           prod_vld_reg;
    logic [kpi_pkg::DATA_W-1:0]     res_reg [kpi_pkg::NUM_FIELDS];

    // path length register, lengths above the store size act as the store size
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_len_reg <= '0;
        end
        else if (path_length_we)
        begin
            cfg_len_reg <= path_length;
        end
    end

    assign len_clamped = (32'(cfg_len_reg) > 32'(kpi_pkg::MAX_KEYS)) ?
                         kpi_pkg::LEN_W'(kpi_pkg::MAX_KEYS) : cfg_len_reg;

    // keyframe store, all five fields in one word
    assign mem_we = cmd.key_write && (32'(key_index) < 32'(kpi_pkg::MAX_KEYS));

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[kpi_pkg::ADDR_W'(key_index)] <= {key_roll, key_zoom, key_z, key_y, key_x};
        end
    end

    // next keyframe wraps to entry 0
    assign k_inc   = {1'b0, rem_reg} + (kpi_pkg::LEN_W + 1)'(1);
    assign rd_addr = cmd.rd_a ? kpi_pkg::ADDR_W'(rem_reg) :
                     ((k_inc == {1'b0, len_reg}) ? '0 : kpi_pkg::ADDR_W'(k_inc));

    always_ff @(posedge clk)
    begin
        if (cmd.rd_a || cmd.rd_b)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // restoring remainder, one integer bit a step
    assign rem_shift = {rem_reg, ipart_reg[kpi_pkg::INT_W-1]};
    assign rem_next  = (rem_shift >= {1'b0, len_reg}) ?
                       kpi_pkg::LEN_W'(rem_shift - {1'b0, len_reg}) :
                       kpi_pkg::LEN_W'(rem_shift);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            len_reg     <= len_clamped;
            ipart_reg   <= position[kpi_pkg::POS_W-1:kpi_pkg::FRAC_BITS];
            frac_reg    <= position[kpi_pkg::FRAC_BITS-1:0];
            rem_reg     <= '0;
            cnt_reg     <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg   <= rem_next;
            ipart_reg <= {ipart_reg[kpi_pkg::INT_W-2:0], 1'b0};
            cnt_reg   <= cnt_reg + kpi_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            path_ok_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            path_ok_reg <= (len_clamped != '0);
        end
    end

    // interpolation, one field a cycle through one multiplier
    assign a_fld     = a_reg[fld_reg * kpi_pkg::DATA_W +: kpi_pkg::DATA_W];
    assign b_fld     = rd_data_reg[fld_reg * kpi_pkg::DATA_W +: kpi_pkg::DATA_W];
    assign diff      = $signed({b_fld[kpi_pkg::DATA_W-1], b_fld})
                     - $signed({a_fld[kpi_pkg::DATA_W-1], a_fld});
    assign prod_next = kpi_pkg::PROD_W'(diff)
                     * kpi_pkg::PROD_W'($signed({1'b0, frac_reg}));

    always_ff @(posedge clk)
    begin
        if (cmd.rd_b)
        begin
            a_reg   <= rd_data_reg;
            fld_reg <= '0;
        end
        else if (cmd.mul_step)
        begin
            fld_reg <= fld_reg + kpi_pkg::FLD_W'(1);
        end
        if (cmd.mul_step)
        begin
            prod_reg     <= prod_next;
            a_hold_reg   <= a_fld;
            prod_fld_reg <= fld_reg;
        end
        // arithmetic shift floors the scaled difference
        if (prod_vld_reg)
        begin
            res_reg[prod_fld_reg] <= a_hold_reg
                                   + kpi_pkg::DATA_W'(prod_reg >>> kpi_pkg::FRAC_BITS);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_vld_reg <= 1'b0;
        end
        else
        begin
            prod_vld_reg <= cmd.mul_step;
        end
    end

    assign status.len_zero = (len_clamped == '0);
    assign status.div_last = (cnt_reg == kpi_pkg::CNT_W'(kpi_pkg::INT_W - 1));
    assign status.fld_last = (fld_reg == kpi_pkg::FLD_W'(kpi_pkg::NUM_FIELDS - 1));

    assign out_x    = path_ok_reg ? res_reg[0] : '0;
    assign out_y    = path_ok_reg ? res_reg[1] : '0;
    assign out_z    = path_ok_reg ? res_reg[2] : '0;
    assign out_zoom = path_ok_reg ? res_reg[3] : '0;
    assign out_roll = path_ok_reg ? res_reg[4] : '0;
    assign path_ok  = path_ok_reg;

    `KPI_ASSERT_SAME(a_rem_in_range, cmd.rd_a, rem_reg < len_reg, "key index not below path length")
    `KPI_ASSERT_SAME(a_next_in_range, cmd.rd_b, kpi_pkg::LEN_W'(rd_addr) < len_reg, "next key index not below path length")
    `KPI_ASSERT_NEXT(a_mul_fills, cmd.mul_step, prod_vld_reg, "product not marked valid")

endmodule

`default_nettype wire
